### sv/unsigned_q2_14_alu_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef UNSIGNED_Q2_14_ALU_UNIT_ASSERT_SVH
`define UNSIGNED_Q2_14_ALU_UNIT_ASSERT_SVH

// Checked only while reset is low.
`define UQA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define UQA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/uq_alu_pkg.sv
package uq_alu_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 14;
  localparam int PROD_W     = 2 * DATA_WIDTH;
  localparam int STATUS_W   = 3;

  // Restoring divider: quotient bits resolved per pipeline stage.
  localparam int DIV_STEPS  = 2;
  localparam int DIV_QW     = DATA_WIDTH + FRAC_BITS + 1;
  localparam int DIV_STAGES = (DIV_QW + DIV_STEPS - 1) / DIV_STEPS;
  localparam int DIV_W      = DIV_STAGES * DIV_STEPS;

  localparam int IN_TDATA_W  = ((2 * DATA_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_ADD_SAT  = 3'd1,
    ST_DIV_ZERO = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_BORROW   = 3'd4
  } status_t;

  // Payload carried down the divider stages.
  typedef struct packed {
    opcode_t                op;
    logic [DATA_WIDTH-1:0]  value;
    status_t                status;
    logic [DATA_WIDTH-1:0]  divisor;
    logic [DATA_WIDTH-1:0]  rem;
    logic [DIV_W-1:0]       nq;
  } pipe_t;

endpackage

### sv/uq_alu_front.sv
module uq_alu_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_vld,
  input  uq_alu_pkg::opcode_t                 in_op,
  input  logic [uq_alu_pkg::DATA_WIDTH-1:0]   in_a,
  input  logic [uq_alu_pkg::DATA_WIDTH-1:0]   in_b,
  output logic                                out_vld,
  output uq_alu_pkg::pipe_t                   out_pipe
);
  import uq_alu_pkg::*;

  localparam logic [PROD_W:0] MUL_HALF = (PROD_W + 1)'(1) << (FRAC_BITS - 1);

  // stage 1
  logic                  vld1;
  opcode_t               op1;
  logic [DATA_WIDTH-1:0] b1;
  logic [PROD_W-1:0]     prod1;
  logic [DIV_W-1:0]      num1;
  logic [DATA_WIDTH-1:0] early_value1;
  status_t               early_status1;

  logic [DATA_WIDTH:0]   add_sum;
  logic [DATA_WIDTH-1:0] early_value_next;
  status_t               early_status_next;

  always_comb begin
    add_sum = {1'b0, in_a} + {1'b0, in_b};
    if (in_op == OP_ADD) begin
      if (add_sum[DATA_WIDTH]) begin
        early_value_next  = '1;
        early_status_next = ST_ADD_SAT;
      end else begin
        early_value_next  = add_sum[DATA_WIDTH-1:0];
        early_status_next = ST_OK;
      end
    end else begin
      early_value_next  = in_a - in_b;
      early_status_next = (in_a < in_b) ? ST_BORROW : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else if (en) begin
      vld1 <= in_vld;
    end
    if (en) begin
      op1           <= in_op;
      b1            <= in_b;
      prod1         <= PROD_W'(in_a) * PROD_W'(in_b);
      num1          <= DIV_W'({in_a, {FRAC_BITS{1'b0}}}) + DIV_W'(in_b >> 1);
      early_value1  <= early_value_next;
      early_status1 <= early_status_next;
    end
  end

  // stage 2: round and scale the product, pass on add/sub results, seed the divider
  logic [PROD_W:0] mul_sum;
  logic [PROD_W:0] mul_shift;
  pipe_t           pipe_next;

  always_comb begin
    mul_sum   = {1'b0, prod1} + MUL_HALF;
    mul_shift = mul_sum >> FRAC_BITS;
    pipe_next.op      = op1;
    pipe_next.divisor = b1;
    pipe_next.rem     = '0;
    pipe_next.nq      = num1;
    if (op1 == OP_MUL) begin
      pipe_next.value  = mul_shift[DATA_WIDTH-1:0];
      pipe_next.status = (|mul_shift[PROD_W:DATA_WIDTH]) ? ST_OVERFLOW : ST_OK;
    end else begin
      pipe_next.value  = early_value1;
      pipe_next.status = early_status1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= vld1;
    end
    if (en) begin
      out_pipe <= pipe_next;
    end
  end

endmodule

### sv/uq_alu_div_stage.sv
module uq_alu_div_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  uq_alu_pkg::pipe_t in_pipe,
  output logic              out_vld,
  output uq_alu_pkg::pipe_t out_pipe
);
  import uq_alu_pkg::*;

  pipe_t pipe_next;

  // restoring division, DIV_STEPS quotient bits per stage
  always_comb begin
    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH-1:0] rem;
    logic [DIV_W-1:0]      nq;
    logic                  ge;
    rem = in_pipe.rem;
    nq  = in_pipe.nq;
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial = {rem, nq[DIV_W-1]};
      ge    = trial >= {1'b0, in_pipe.divisor};
      if (ge) begin
        trial = trial - {1'b0, in_pipe.divisor};
      end
      rem = trial[DATA_WIDTH-1:0];
      nq  = {nq[DIV_W-2:0], ge};
    end
    pipe_next     = in_pipe;
    pipe_next.rem = rem;
    pipe_next.nq  = nq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
    if (en) begin
      out_pipe <= pipe_next;
    end
  end

endmodule

### sv/unsigned_q2_14_alu_unit.sv
// Unsigned Q2.14 fixed-point ALU: add (saturating), subtract (wrapping, borrow
// flag), multiply (round half up) and divide (rounded, divide-by-zero flag).
// Input stream: s_axis_tuser carries the opcode, s_axis_tdata the operands.
// Output stream: m_axis_tdata carries the result, m_axis_tuser the status.
// The pipe has two front stages (operand prep and multiply, then product
// rounding), one stage per two quotient bits of the restoring divider, and
// the output register; every opcode runs through all of them. The divider
// chain sets the pipe's depth. Throughput is one request per cycle while the
// output is not stalled; all opcodes share the same pipe, so results leave
// in request order.
// The whole pipe advances together: when the output holds a result the
// receiver does not take, every stage freezes and s_axis_tready drops in the
// same cycle. Nothing is dropped or duplicated.
// Reset (rst, synchronous, active high) clears all valid bits; the data
// registers are not reset, and the block accepts requests in the cycle after reset.
module unsigned_q2_14_alu_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // operand_a, operand_b
  input  logic [uq_alu_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // opcode
  input  logic [1:0]                           s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // result_value
  output logic [uq_alu_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // status_code
  output logic [uq_alu_pkg::STATUS_W-1:0]      m_axis_tuser
);
  import uq_alu_pkg::*;

  logic  en;
  logic  vld   [0:DIV_STAGES];
  pipe_t stage [0:DIV_STAGES];

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  uq_alu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (s_axis_tvalid),
    .in_op    (opcode_t'(s_axis_tuser)),
    .in_a     (s_axis_tdata[DATA_WIDTH-1:0]),
    .in_b     (s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
    .out_vld  (vld[0]),
    .out_pipe (stage[0])
  );

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    uq_alu_div_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_vld   (vld[i]),
      .in_pipe  (stage[i]),
      .out_vld  (vld[i+1]),
      .out_pipe (stage[i+1])
    );
  end

  pipe_t                 last;
  logic [DATA_WIDTH-1:0] value_next;
  status_t               status_next;

  assign last = stage[DIV_STAGES];

  always_comb begin
    value_next  = last.value;
    status_next = last.status;
    if (last.op == OP_DIV) begin
      if (last.divisor == '0) begin
        value_next  = '1;
        status_next = ST_DIV_ZERO;
      end else begin
        value_next  = last.nq[DATA_WIDTH-1:0];
        status_next = (|last.nq[DIV_W-1:DATA_WIDTH]) ? ST_OVERFLOW : ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= vld[DIV_STAGES];
    end
    if (en) begin
      m_axis_tdata <= OUT_TDATA_W'(value_next);
      m_axis_tuser <= status_next;
    end
  end

endmodule

### sv/uq_alu_checker.sv
`include "unsigned_q2_14_alu_unit_assert.svh"

module uq_alu_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic [uq_alu_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input logic [1:0]                          s_axis_tuser,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [uq_alu_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic [uq_alu_pkg::STATUS_W-1:0]     m_axis_tuser
);
  import uq_alu_pkg::*;

  `UQA_ASSERT_ALWAYS(a_reset_clears, rst |=> !m_axis_tvalid, "output valid after reset")

  `UQA_ASSERT(a_ready_when_free, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")

  `UQA_ASSERT(a_sat_all_ones, m_axis_tvalid && (m_axis_tuser == ST_ADD_SAT || m_axis_tuser == ST_DIV_ZERO) |-> (&m_axis_tdata[DATA_WIDTH-1:0]), "saturated result not all ones")

  `UQA_ASSERT(a_status_range, m_axis_tvalid |-> m_axis_tuser <= ST_BORROW, "status code out of range")

  `UQA_ASSERT(a_hold_on_stall, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind unsigned_q2_14_alu_unit uq_alu_checker u_checker (.*);

### dv/tb_unsigned_q2_14_alu_unit.sv
module tb_unsigned_q2_14_alu_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import uq_alu_pkg::*;

  localparam int RANDOM_REQUESTS = 1500;
  localparam int DRAIN_CYCLES    = 40;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int LONG_HOLD       = 250;
  localparam logic [DATA_WIDTH-1:0] ALL_ONES = '1;

  typedef struct {
    logic [DATA_WIDTH-1:0] value;
    status_t               status;
  } alu_result_t;

  // Expected ALU results, oldest first, plus the comparison against the DUT.
  class alu_result_tracker;
    alu_result_t pending_results[$];
    int          errors;

    function new();
      errors = 0;
    endfunction

    function alu_result_t q214_compute(opcode_t op, logic [DATA_WIDTH-1:0] a,
                                       logic [DATA_WIDTH-1:0] b);
      logic [63:0] wide;
      alu_result_t r;
      r.status = ST_OK;
      r.value  = '0;
      case (op)
        OP_ADD: begin
          wide = 64'(a) + 64'(b);
          if (wide > 64'(ALL_ONES)) begin
            r.value  = ALL_ONES;
            r.status = ST_ADD_SAT;
          end else begin
            r.value = wide[DATA_WIDTH-1:0];
          end
        end
        OP_SUB: begin
          r.value = a - b;
          if (a < b) r.status = ST_BORROW;
        end
        OP_MUL: begin
          // round half up before dropping the fraction bits
          wide = (64'(a) * 64'(b) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
          if (wide > 64'(ALL_ONES)) r.status = ST_OVERFLOW;
          r.value = wide[DATA_WIDTH-1:0];
        end
        default: begin
          if (b == '0) begin
            r.value  = ALL_ONES;
            r.status = ST_DIV_ZERO;
          end else begin
            wide = ((64'(a) << FRAC_BITS) + 64'(b >> 1)) / 64'(b);
            if (wide > 64'(ALL_ONES)) r.status = ST_OVERFLOW;
            r.value = wide[DATA_WIDTH-1:0];
          end
        end
      endcase
      return r;
    endfunction

    function void note_request(opcode_t op, logic [DATA_WIDTH-1:0] a,
                               logic [DATA_WIDTH-1:0] b);
      pending_results.push_back(q214_compute(op, a, b));
    endfunction

    function void check_result(logic [DATA_WIDTH-1:0] value, logic [STATUS_W-1:0] status);
      alu_result_t exp;
      if (pending_results.size() == 0) begin
        $error("unexpected result: result_value %h status_code %0d", value, status);
        errors++;
        return;
      end
      exp = pending_results.pop_front();
      if (value !== exp.value) begin
        $error("result_value mismatch: expected %h, actual %h", exp.value, value);
        errors++;
      end
      if (status !== exp.status) begin
        $error("status_code mismatch: expected %0d, actual %0d", exp.status, status);
        errors++;
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
  logic [1:0]              s_axis_tuser = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;
  logic [STATUS_W-1:0]     m_axis_tuser;

  alu_result_tracker book = new();
  int  results_taken = 0;
  int  cycles = 0;
  bit  hold_active = 1'b0;
  bit  send_burst = 1'b0;
  bit  recv_burst = 1'b0;

  unsigned_q2_14_alu_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      book.check_result(m_axis_tdata[DATA_WIDTH-1:0], m_axis_tuser);
      results_taken++;
    end
  end

  function automatic int send_gap();
    if ($urandom_range(0, 63) == 0) send_burst = ~send_burst;
    if (send_burst || hold_active) return 0;
    return $urandom_range(0, 12);
  endfunction

  function automatic logic [DATA_WIDTH-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ALL_ONES;
      2:       return DATA_WIDTH'($urandom_range(0, 255));
      3:       return ALL_ONES - DATA_WIDTH'($urandom_range(0, 255));
      4:       return DATA_WIDTH'(16'h4000 + $urandom_range(0, 64) - 32);
      default: return DATA_WIDTH'($urandom);
    endcase
  endfunction

  task automatic send_request(opcode_t op, logic [DATA_WIDTH-1:0] a,
                              logic [DATA_WIDTH-1:0] b);
    int gap;
    gap = send_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, a};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    book.note_request(op, a, b);
  endtask

  // result side: random stalls, burst stretches, one long hold-off
  initial begin
    int  stall;
    bit  held_long;
    held_long = 1'b0;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 63) == 0) recv_burst = ~recv_burst;
      stall = recv_burst ? 0 : $urandom_range(0, 12);
      if (!held_long && results_taken >= 300) begin
        held_long   = 1'b1;
        hold_active = 1'b1;
        stall       = LONG_HOLD;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      hold_active = 1'b0;
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // add: zero, saturation edges
    send_request(OP_ADD, 16'h0000, 16'h0000);
    send_request(OP_ADD, 16'hffff, 16'hffff);
    send_request(OP_ADD, 16'hffff, 16'h0001);
    send_request(OP_ADD, 16'h8000, 16'h7fff);
    // subtract: borrow and wrap
    send_request(OP_SUB, 16'h0000, 16'h0000);
    send_request(OP_SUB, 16'h0000, 16'hffff);
    send_request(OP_SUB, 16'hffff, 16'h0000);
    send_request(OP_SUB, 16'h0005, 16'h0005);
    // multiply: rounding boundary, 1.0 * 1.0, overflow
    send_request(OP_MUL, 16'h0000, 16'h0000);
    send_request(OP_MUL, 16'hffff, 16'hffff);
    send_request(OP_MUL, 16'h4000, 16'h4000);
    send_request(OP_MUL, 16'h2000, 16'h0001);
    send_request(OP_MUL, 16'h1fff, 16'h0001);
    send_request(OP_MUL, 16'h0001, 16'h0001);
    send_request(OP_MUL, 16'hffff, 16'h4000);
    // divide: by zero, overflow, exact and rounded quotients
    send_request(OP_DIV, 16'hffff, 16'h0000);
    send_request(OP_DIV, 16'h0000, 16'h0000);
    send_request(OP_DIV, 16'h0000, 16'hffff);
    send_request(OP_DIV, 16'hffff, 16'h0001);
    send_request(OP_DIV, 16'h4000, 16'h4000);
    send_request(OP_DIV, 16'h0001, 16'hffff);
    send_request(OP_DIV, 16'hffff, 16'hffff);
    send_request(OP_DIV, 16'h0001, 16'h0003);

    repeat (RANDOM_REQUESTS)
      send_request(opcode_t'($urandom_range(0, 3)), pick_operand(), pick_operand());
    s_axis_tvalid <= 1'b0;

    while (book.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (book.errors == 0 && book.pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/uq_alu_pkg.sv
sv/uq_alu_front.sv
sv/uq_alu_div_stage.sv
sv/unsigned_q2_14_alu_unit.sv
sv/uq_alu_checker.sv
dv/tb_unsigned_q2_14_alu_unit.sv
